// ===== design/frs_pkg.sv =====
// Shared types and constants of the floppy read sequencer.
// Used by the front end, the job queue, the back end, the top level and the checker.
package frs_pkg;

    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int DIV_W   = 16;
    localparam int BLK_SH  = 9;

    // Controller command bytes
    localparam logic [7:0] OP_SEEK    = 8'h0F;
    localparam logic [7:0] OP_READ    = 8'hE6;
    localparam logic [7:0] CMD_SENSE  = 8'h08;
    localparam logic [7:0] OP_RECAL   = 8'h07;
    localparam logic [7:0] SECT_SIZE  = 8'h02;
    localparam logic [7:0] DTL_BYTE   = 8'hFF;
    localparam logic [7:0] ST0_ERR    = 8'hC0;
    localparam logic [7:0] TRACK_UNK  = 8'hFF;
    localparam logic [2:0] RES_LAST   = 3'd6;

    // Input word modes; the last one is reserved and dropped
    localparam logic [1:0] MODE_REQ  = 2'd0;
    localparam logic [1:0] MODE_INT  = 2'd1;
    localparam logic [1:0] MODE_RES  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CMD     = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_SEEKERR = 2'd2;
    localparam logic [1:0] KIND_RETRY   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_HEADS = 3'd0;
    localparam logic [2:0] CFG_SPT   = 3'd1;
    localparam logic [2:0] CFG_GAP   = 3'd2;
    localparam logic [2:0] CFG_DRIVE = 3'd3;
    localparam logic [2:0] CFG_RETRY = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SEEK_INT, PH_SEEK_SENSE, PH_READ_INT,
        PH_READ_RES, PH_RECAL_INT, PH_RECAL_SENSE
    } phase_t;

    typedef enum logic [1:0] { F_READY, F_DIV, F_CHUNK } ffsm_t;

    typedef enum logic [2:0] { JOB_SEEK, JOB_READ, JOB_SENSE, JOB_RECAL, JOB_STATUS } job_kind_t;

    typedef struct packed {
        logic [1:0] head_count;
        logic [5:0] spt;
        logic [7:0] gap;
        logic [1:0] drive;
        logic [3:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        job_kind_t   jk;
        logic [1:0]  kind;
        logic [7:0]  track;
        logic        head;
        logic [5:0]  sector;
        logic [5:0]  spt;
        logic [7:0]  gap;
        logic [1:0]  drive;
        logic [15:0] dma;
        logic [19:0] done;
    } job_t;

endpackage

// ===== design/floppy_read_sequencer.sv =====
// Top level of the floppy read sequencer: configuration registers, front end,
// job queue and back end. Depends on frs_pkg, frs_front, frs_queue and frs_back.
//
// Each input word (a read request, a controller interrupt or a result byte)
// gives at most one job and so at most nine result words. Interrupts and result
// bytes are handled directly in the front end. A request, and a successful read that
// leaves bytes to do, runs the serial block divider and then the chunk step before
// the next word can be taken. The back end sends one word a cycle while the output
// is not stalled, with a gap between jobs, while a four-job queue lets the front
// end keep taking words. Configuration writes are always accepted.
module floppy_read_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // start_block[15:0], byte_count[35:16], status_byte[43:36]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // cmd_byte[7:0], dma_count[23:8], bytes_done[43:24]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast
);
    import frs_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        push, pop, q_empty, q_full;
    job_t        push_job, pop_job;
    logic [7:0]  cmd;
    logic [15:0] dma;
    logic [19:0] done;

    assign cfg_ready = 1'b1;

    // Register writes; indexes past the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADS: cfg_next.head_count  = cfg_data[1:0];
                CFG_SPT:   cfg_next.spt         = cfg_data[5:0];
                CFG_GAP:   cfg_next.gap         = cfg_data;
                CFG_DRIVE: cfg_next.drive       = cfg_data[1:0];
                CFG_RETRY: cfg_next.retry_limit = cfg_data[3:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_count  <= 2'd2;
            cfg_reg.spt         <= 6'd18;
            cfg_reg.gap         <= 8'd27;
            cfg_reg.drive       <= 2'd0;
            cfg_reg.retry_limit <= 4'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: phase tracking and chunking
    frs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_block  (s_axis_tdata[15:0]),
        .in_count  (s_axis_tdata[35:16]),
        .in_status (s_axis_tdata[43:36]),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Hold pending jobs so either side can stall
    frs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back end: expand jobs into words
    frs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_cmd   (cmd),
        .out_dma   (dma),
        .out_done  (done),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, done, dma, cmd};
endmodule

// ===== design/frs_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on frs_pkg for the job type and depth.
module frs_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frs_pkg::job_t push_job,
    input  logic          pop,
    output frs_pkg::job_t pop_job,
    output logic          empty,
    output logic          full
);
    import frs_pkg::*;

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign pop_job = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end
endmodule

// ===== design/frs_front.sv =====
// Front end: accepts input words, tracks the controller phase, splits requests
// into chunks with a serial block divider and pushes at most one job per word. Uses frs_pkg.
module frs_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  frs_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_mode,
    input  logic [15:0]   in_block,
    input  logic [19:0]   in_count,
    input  logic [7:0]    in_status,
    input  logic          q_full,
    output logic          push,
    output frs_pkg::job_t push_job
);
    import frs_pkg::*;

    ffsm_t       fsm_reg, fsm_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  cur_track_reg, cur_track_next;
    logic [7:0]  tgt_track_reg, tgt_track_next;
    logic        tgt_head_reg, tgt_head_next;
    logic [5:0]  tgt_sector_reg, tgt_sector_next;
    logic [15:0] chunk_reg, chunk_next;
    logic [19:0] left_reg, left_next;
    logic [19:0] total_reg, total_next;
    logic [15:0] nblk_reg, nblk_next;
    logic [3:0]  retries_reg, retries_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [7:0]  st0_reg, st0_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [5:0]  rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic        acc, two_heads;
    logic [5:0]  spt_eff;
    logic [6:0]  trial;
    logic [6:0]  room_sec;
    logic [15:0] room;
    logic        attempt;

    assign in_ready  = (fsm_reg == F_READY) && !q_full;
    assign acc       = in_valid && in_ready;
    assign two_heads = cfg.head_count[1];
    assign spt_eff   = (cfg.spt == '0) ? 6'd1 : cfg.spt;

    always_comb
    begin
        fsm_next        = fsm_reg;
        phase_next      = phase_reg;
        cur_track_next  = cur_track_reg;
        tgt_track_next  = tgt_track_reg;
        tgt_head_next   = tgt_head_reg;
        tgt_sector_next = tgt_sector_reg;
        chunk_next      = chunk_reg;
        left_next       = left_reg;
        total_next      = total_reg;
        nblk_next       = nblk_reg;
        retries_next    = retries_reg;
        ridx_next       = ridx_reg;
        st0_next        = st0_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        push            = 1'b0;
        attempt         = 1'b0;
        push_job        = '0;
        push_job.jk     = JOB_STATUS;
        trial           = {rem_reg, quo_reg[DIV_W-1]};
        room_sec        = '0;
        room            = '0;

        case (fsm_reg)
            F_DIV:
            begin
                // one restoring step per cycle
                if (trial >= {1'b0, spt_eff})
                begin
                    rem_next = 6'(trial - {1'b0, spt_eff});
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[5:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    fsm_next = F_CHUNK;
                end
            end
            F_CHUNK:
            begin
                tgt_track_next  = two_heads ? quo_reg[8:1] : quo_reg[7:0];
                tgt_head_next   = two_heads & quo_reg[0];
                tgt_sector_next = rem_reg + 6'd1;
                room_sec = 7'(spt_eff - rem_reg)
                         + ((two_heads && !quo_reg[0]) ? {1'b0, spt_eff} : 7'd0);
                room     = {room_sec, 9'd0};
                chunk_next   = (left_reg < {4'd0, room}) ? left_reg[15:0] : room;
                retries_next = (cfg.retry_limit == '0) ? 4'd1 : cfg.retry_limit;
                attempt  = 1'b1;
                fsm_next = F_READY;
            end
            default:
            begin
                if (acc)
                begin
                    case (in_mode)
                        MODE_REQ:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                nblk_next  = in_block;
                                total_next = in_count;
                                left_next  = in_count;
                                if (in_count == '0)
                                begin
                                    push          = 1'b1;
                                    push_job.kind = KIND_DONE;
                                end
                                else
                                begin
                                    quo_next = in_block;
                                    rem_next = '0;
                                    cnt_next = '0;
                                    fsm_next = F_DIV;
                                end
                            end
                        end
                        MODE_INT:
                        begin
                            if (phase_reg == PH_SEEK_INT || phase_reg == PH_RECAL_INT)
                            begin
                                push        = 1'b1;
                                push_job.jk = JOB_SENSE;
                                phase_next  = (phase_reg == PH_SEEK_INT) ? PH_SEEK_SENSE
                                                                         : PH_RECAL_SENSE;
                                ridx_next   = '0;
                            end
                            else if (phase_reg == PH_READ_INT)
                            begin
                                phase_next = PH_READ_RES;
                                ridx_next  = '0;
                            end
                        end
                        MODE_RES:
                        begin
                            case (phase_reg)
                                PH_SEEK_SENSE:
                                begin
                                    if (ridx_reg == '0)
                                    begin
                                        st0_next  = in_status;
                                        ridx_next = 3'd1;
                                    end
                                    else if (in_status != tgt_track_reg)
                                    begin
                                        push          = 1'b1;
                                        push_job.kind = KIND_SEEKERR;
                                        push_job.done = total_reg - left_reg;
                                        phase_next    = PH_IDLE;
                                    end
                                    else
                                    begin
                                        cur_track_next = in_status;
                                        attempt        = 1'b1;
                                    end
                                end
                                PH_READ_RES:
                                begin
                                    if (ridx_reg == '0)
                                    begin
                                        st0_next = in_status;
                                    end
                                    if (ridx_reg < RES_LAST)
                                    begin
                                        ridx_next = ridx_reg + 1'b1;
                                    end
                                    else if ((st0_reg & ST0_ERR) == '0)
                                    begin
                                        left_next = left_reg - {4'd0, chunk_reg};
                                        nblk_next = nblk_reg + 16'(chunk_reg >> BLK_SH);
                                        if (left_next == '0)
                                        begin
                                            push          = 1'b1;
                                            push_job.kind = KIND_DONE;
                                            push_job.done = total_reg;
                                            phase_next    = PH_IDLE;
                                        end
                                        else
                                        begin
                                            quo_next = nblk_next;
                                            rem_next = '0;
                                            cnt_next = '0;
                                            fsm_next = F_DIV;
                                        end
                                    end
                                    else
                                    begin
                                        cur_track_next = '0;
                                        push           = 1'b1;
                                        push_job.jk    = JOB_RECAL;
                                        phase_next     = PH_RECAL_INT;
                                    end
                                end
                                PH_RECAL_SENSE:
                                begin
                                    if (ridx_reg == '0)
                                    begin
                                        st0_next  = in_status;
                                        ridx_next = 3'd1;
                                    end
                                    else
                                    begin
                                        retries_next = retries_reg - 1'b1;
                                        if (retries_next == '0)
                                        begin
                                            push          = 1'b1;
                                            push_job.kind = KIND_RETRY;
                                            push_job.done = total_reg - left_reg;
                                            phase_next    = PH_IDLE;
                                        end
                                        else
                                        begin
                                            attempt = 1'b1;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase

        // start an attempt: seek when off track, else the read command
        if (attempt)
        begin
            push = 1'b1;
            push_job.kind = KIND_CMD;
            if (cur_track_next != tgt_track_next)
            begin
                push_job.jk = JOB_SEEK;
                phase_next  = PH_SEEK_INT;
            end
            else
            begin
                push_job.jk  = JOB_READ;
                push_job.dma = chunk_next - 16'd1;
                phase_next   = PH_READ_INT;
            end
        end
        push_job.track  = tgt_track_next;
        push_job.head   = tgt_head_next;
        push_job.sector = tgt_sector_next;
        push_job.spt    = spt_eff;
        push_job.gap    = cfg.gap;
        push_job.drive  = cfg.drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= F_READY;
            phase_reg      <= PH_IDLE;
            cur_track_reg  <= TRACK_UNK;
            tgt_track_reg  <= '0;
            tgt_head_reg   <= 1'b0;
            tgt_sector_reg <= '0;
            chunk_reg      <= '0;
            left_reg       <= '0;
            total_reg      <= '0;
            nblk_reg       <= '0;
            retries_reg    <= '0;
            ridx_reg       <= '0;
            st0_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            phase_reg      <= phase_next;
            cur_track_reg  <= cur_track_next;
            tgt_track_reg  <= tgt_track_next;
            tgt_head_reg   <= tgt_head_next;
            tgt_sector_reg <= tgt_sector_next;
            chunk_reg      <= chunk_next;
            left_reg       <= left_next;
            total_reg      <= total_next;
            nblk_reg       <= nblk_next;
            retries_reg    <= retries_next;
            ridx_reg       <= ridx_next;
            st0_reg        <= st0_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
endmodule

// ===== design/frs_back.sv =====
// Back end: expands queued jobs into result words in an output register.
// Uses frs_pkg for the job type and command bytes.
module frs_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  frs_pkg::job_t q_job,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_cmd,
    output logic [15:0]   out_dma,
    output logic [19:0]   out_done,
    output logic          out_last
);
    import frs_pkg::*;

    job_t        job_reg;
    logic        jv_reg, jv_next;
    logic [3:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] dma_reg;
    logic [19:0] done_reg;
    logic        last_reg;
    logic        adv, load;
    logic [7:0]  b;
    logic [3:0]  nbytes;
    logic [7:0]  sel;

    assign adv       = !ov_reg || out_ready;
    assign load      = jv_reg && adv;
    assign q_pop     = !jv_reg && !q_empty;
    assign out_valid = ov_reg;
    assign out_kind  = kind_reg;
    assign out_cmd   = cmd_reg;
    assign out_dma   = dma_reg;
    assign out_done  = done_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        sel    = {5'd0, job_reg.head, job_reg.drive};
        b      = '0;
        nbytes = 4'd1;
        case (job_reg.jk)
            JOB_SEEK:
            begin
                nbytes = 4'd3;
                case (idx_reg)
                    4'd0:    b = OP_SEEK;
                    4'd1:    b = sel;
                    default: b = job_reg.track;
                endcase
            end
            JOB_READ:
            begin
                nbytes = 4'd9;
                case (idx_reg)
                    4'd0:    b = OP_READ;
                    4'd1:    b = sel;
                    4'd2:    b = job_reg.track;
                    4'd3:    b = {7'd0, job_reg.head};
                    4'd4:    b = {2'd0, job_reg.sector};
                    4'd5:    b = SECT_SIZE;
                    4'd6:    b = {2'd0, job_reg.spt};
                    4'd7:    b = job_reg.gap;
                    default: b = DTL_BYTE;
                endcase
            end
            JOB_SENSE: b = CMD_SENSE;
            JOB_RECAL:
            begin
                nbytes = 4'd2;
                b      = (idx_reg == '0) ? OP_RECAL : {6'd0, job_reg.drive};
            end
            default: b = '0;
        endcase

        jv_next  = jv_reg;
        idx_next = idx_reg;
        ov_next  = ov_reg;
        if (load)
        begin
            ov_next  = 1'b1;
            idx_next = idx_reg + 1'b1;
            if (idx_next == nbytes)
            begin
                jv_next = 1'b0;
            end
        end
        else if (adv)
        begin
            ov_next = 1'b0;
        end
        if (q_pop)
        begin
            jv_next  = 1'b1;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg  <= 1'b0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            jv_reg  <= jv_next;
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (load)
        begin
            kind_reg <= job_reg.kind;
            cmd_reg  <= b;
            dma_reg  <= (job_reg.jk == JOB_READ) ? job_reg.dma : 16'd0;
            done_reg <= job_reg.done;
            last_reg <= (idx_next == nbytes);
        end
    end
endmodule

// ===== design/frs_checker.sv =====
// Port-level checker for the floppy read sequencer, bound to the top level.
// Depends on frs_pkg for the result kind codes.
module frs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import frs_pkg::*;

    // Status words always end their burst
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_CMD |-> m_axis_tlast)
        else $error("status word without tlast");

    // DMA count only rides on command bytes
    a_dma_cmd_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_CMD |-> m_axis_tdata[23:8] == 16'd0)
        else $error("dma count on status word");

    // Command bytes carry no byte total
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_CMD |-> m_axis_tdata[43:24] == 20'd0)
        else $error("bytes done on command byte");

    // Stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");
endmodule

bind floppy_read_sequencer frs_checker u_frs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the floppy read sequencer: directed table plus
// controller-aware random traffic, checked against an in-bench sequencing model.
// Depends on frs_pkg and floppy_read_sequencer.
module tb_top;
    import frs_pkg::*;

    // one result word as seen on the master side
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  cmd;
        logic [15:0] dma;
        logic [19:0] done;
        logic        last;
    } res_word_t;

    // one row of the directed table; typed rows carry their single expected word
    typedef struct {
        logic [1:0]  mode;
        logic [15:0] blk;
        logic [19:0] cnt;
        logic [7:0]  st;
        bit          typed;
        logic [1:0]  t_kind;
        logic [7:0]  t_cmd;
        logic [19:0] t_done;
    } row_t;

    localparam int WATCH_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 80;
    localparam int SEG_ITEMS   = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    floppy_read_sequencer i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer model: geometry registers and request state
    // ------------------------------------------------------------------
    logic [1:0]  g_heads;
    logic [5:0]  g_spt;
    logic [7:0]  g_gap;
    logic [1:0]  g_drive;
    logic [3:0]  g_retry;

    phase_t      m_phase;
    logic [7:0]  m_cur_trk, m_trk;
    logic        m_head;
    logic [5:0]  m_sect;
    logic [19:0] m_chunk, m_left, m_total;
    logic [15:0] m_blk;
    logic [3:0]  m_retries;
    logic [2:0]  m_res_idx;
    logic [7:0]  m_st0;

    res_word_t   cmd_words[$];   // expected result words, oldest first

    int errors;
    int words_seen;
    int reqs_done, seek_fails, retry_outs;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;

    function automatic void push_word(logic [1:0] k, logic [7:0] c, logic [15:0] d,
                                      logic [19:0] dn);
        res_word_t w;
        w.kind = k; w.cmd = c; w.dma = d; w.done = dn; w.last = 1'b0;
        cmd_words.push_back(w);
    endfunction

    function automatic int eff_heads();
        if (g_heads == 2'd0) return 1;
        if (g_heads == 2'd3) return 2;
        return int'(g_heads);
    endfunction

    function automatic int eff_spt();
        return (g_spt == 6'd0) ? 1 : int'(g_spt);
    endfunction

    // issue seek or full read command for the current chunk
    function automatic void begin_attempt();
        logic [7:0]  sel;
        logic [15:0] d;
        sel = {5'd0, m_head, g_drive};
        if (m_cur_trk != m_trk) begin
            push_word(KIND_CMD, OP_SEEK, '0, '0);
            push_word(KIND_CMD, sel, '0, '0);
            push_word(KIND_CMD, m_trk, '0, '0);
            m_phase = PH_SEEK_INT;
        end else begin
            d = 16'(m_chunk - 20'd1);
            push_word(KIND_CMD, OP_READ, d, '0);
            push_word(KIND_CMD, sel, d, '0);
            push_word(KIND_CMD, m_trk, d, '0);
            push_word(KIND_CMD, {7'd0, m_head}, d, '0);
            push_word(KIND_CMD, {2'd0, m_sect}, d, '0);
            push_word(KIND_CMD, SECT_SIZE, d, '0);
            push_word(KIND_CMD, 8'(eff_spt()), d, '0);
            push_word(KIND_CMD, g_gap, d, '0);
            push_word(KIND_CMD, DTL_BYTE, d, '0);
            m_phase = PH_READ_INT;
        end
    endfunction

    // map next block to track/head/sector and size the chunk to the cylinder end
    function automatic void begin_chunk();
        int h, s, b, room;
        h = eff_heads();
        s = eff_spt();
        b = int'(m_blk);
        m_trk  = 8'(b / (h * s));
        m_head = 1'((b / s) % h);
        m_sect = 6'(b % s + 1);
        room = ((s + 1 - int'(m_sect)) + s * (h - int'(m_head) - 1)) * 512;
        m_chunk = (int'(m_left) < room) ? m_left : 20'(room);
        m_retries = (g_retry == 4'd0) ? 4'd1 : g_retry;
        begin_attempt();
    endfunction

    // advance the model by one accepted input word; returns words produced
    function automatic int sequence_word(logic [1:0] md, logic [15:0] blk,
                                         logic [19:0] cnt, logic [7:0] st);
        int n0;
        logic [19:0] dsf;
        n0 = cmd_words.size();
        dsf = m_total - m_left;
        case (md)
            MODE_REQ:
                if (m_phase == PH_IDLE) begin
                    m_blk = blk;
                    m_total = cnt;
                    m_left = cnt;
                    if (cnt == 20'd0) push_word(KIND_DONE, '0, '0, '0);
                    else begin_chunk();
                end
            MODE_INT:
                if (m_phase == PH_SEEK_INT || m_phase == PH_RECAL_INT) begin
                    push_word(KIND_CMD, CMD_SENSE, '0, '0);
                    m_phase = phase_t'(m_phase + 1);
                    m_res_idx = '0;
                end else if (m_phase == PH_READ_INT) begin
                    m_phase = PH_READ_RES;
                    m_res_idx = '0;
                end
            MODE_RES:
                if (m_phase == PH_SEEK_SENSE) begin
                    if (m_res_idx == 3'd0) begin
                        m_st0 = st;
                        m_res_idx = 3'd1;
                    end else if (st != m_trk) begin
                        push_word(KIND_SEEKERR, '0, '0, dsf);
                        m_phase = PH_IDLE;
                    end else begin
                        m_cur_trk = st;
                        begin_attempt();
                    end
                end else if (m_phase == PH_READ_RES) begin
                    if (m_res_idx == 3'd0) m_st0 = st;
                    if (m_res_idx < RES_LAST) begin
                        m_res_idx++;
                    end else if ((m_st0 & ST0_ERR) == 8'd0) begin
                        m_left = m_left - m_chunk;
                        m_blk = m_blk + 16'(m_chunk >> BLK_SH);
                        if (m_left == 20'd0) begin
                            push_word(KIND_DONE, '0, '0, m_total);
                            m_phase = PH_IDLE;
                        end else begin
                            begin_chunk();
                        end
                    end else begin
                        m_cur_trk = 8'd0;
                        push_word(KIND_CMD, OP_RECAL, '0, '0);
                        push_word(KIND_CMD, {6'd0, g_drive}, '0, '0);
                        m_phase = PH_RECAL_INT;
                    end
                end else if (m_phase == PH_RECAL_SENSE) begin
                    if (m_res_idx == 3'd0) begin
                        m_st0 = st;
                        m_res_idx = 3'd1;
                    end else begin
                        m_retries = m_retries - 4'd1;
                        if (m_retries == 4'd0) begin
                            push_word(KIND_RETRY, '0, '0, dsf);
                            m_phase = PH_IDLE;
                        end else begin
                            begin_attempt();
                        end
                    end
                end
            default: ;
        endcase
        if (cmd_words.size() > n0) cmd_words[cmd_words.size() - 1].last = 1'b1;
        return cmd_words.size() - n0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall and field-by-field compare
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
        errors++;
        $display("MISMATCH word %0d %s: got 0x%0h want 0x%0h", words_seen, what, got, want);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        res_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cmd_words.size() == 0) begin
                flag_mismatch("with nothing pending, kind", 20'(m_axis_tuser), 20'd0);
            end else begin
                w = cmd_words.pop_front();
                if (m_axis_tuser != w.kind)
                    flag_mismatch("kind", 20'(m_axis_tuser), 20'(w.kind));
                if (m_axis_tdata[7:0] != w.cmd)
                    flag_mismatch("cmd", 20'(m_axis_tdata[7:0]), 20'(w.cmd));
                if (m_axis_tdata[23:8] != w.dma)
                    flag_mismatch("dma", 20'(m_axis_tdata[23:8]), 20'(w.dma));
                if (m_axis_tdata[43:24] != w.done)
                    flag_mismatch("done", m_axis_tdata[43:24], w.done);
                if (m_axis_tlast != w.last)
                    flag_mismatch("last", 20'(m_axis_tlast), 20'(w.last));
                if (w.kind == KIND_DONE) reqs_done++;
                if (w.kind == KIND_SEEKERR) seek_fails++;
                if (w.kind == KIND_RETRY) retry_outs++;
            end
            words_seen++;
        end
    end

    // Watchdog: any handshake on any channel resets the quiet counter.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Watchdog expired with %0d words pending", cmd_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Drop valid for a random gap, then present one word and hold until taken.
    task automatic send_word(input logic [1:0] md, input logic [15:0] blk,
                             input logic [19:0] cnt, input logic [7:0] st);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = md;
        s_axis_tdata  = {4'd0, st, cnt, blk};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Write one register and mirror it into the model.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_HEADS: g_heads = val[1:0];
            CFG_SPT:   g_spt   = val[5:0];
            CFG_GAP:   g_gap   = val;
            CFG_DRIVE: g_drive = val[1:0];
            CFG_RETRY: g_retry = val[3:0];
            default: ;
        endcase
    endtask

    // Wait for every pending word, then let the back end settle.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (cmd_words.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic load_geometry(input logic [7:0] h, input logic [7:0] s,
                                 input logic [7:0] g, input logic [7:0] d,
                                 input logic [7:0] r);
        write_reg(CFG_HEADS, h);
        write_reg(CFG_SPT, s);
        write_reg(CFG_GAP, g);
        write_reg(CFG_DRIVE, d);
        write_reg(CFG_RETRY, r);
    endtask

    // Play the controller: pick the next word from what the model is waiting for.
    task automatic controller_traffic(input int n_items);
        int done_items, cyl, pick, dummy;
        logic [1:0]  md;
        logic [15:0] blk;
        logic [19:0] cnt;
        logic [7:0]  st;
        done_items = 0;
        while (done_items < n_items || m_phase != PH_IDLE) begin
            blk = 16'($urandom);
            cnt = 20'($urandom);
            st  = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 8) begin
                // noise: busy requests, stray events, reserved mode
                md = (m_phase == PH_IDLE) ? 2'($urandom_range(1, 3)) : 2'($urandom_range(0, 3));
            end else begin
                done_items++;
                case (m_phase)
                    PH_IDLE: begin
                        md = MODE_REQ;
                        cyl = eff_heads() * eff_spt() * 512;
                        if (pick < 12) cnt = '0;
                        else cnt = 20'($urandom_range(1, 3 * cyl));
                    end
                    PH_SEEK_INT, PH_READ_INT, PH_RECAL_INT: md = MODE_INT;
                    PH_SEEK_SENSE: begin
                        md = MODE_RES;
                        // land on the target except now and then
                        if (m_res_idx != 3'd0 && pick >= 15) st = m_trk;
                    end
                    PH_READ_RES: begin
                        md = MODE_RES;
                        if (m_res_idx == 3'd0 && pick >= 30) st = st & ~ST0_ERR;
                    end
                    default: md = MODE_RES;
                endcase
            end
            dummy = sequence_word(md, blk, cnt, st);
            send_word(md, blk, cnt, st);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: empty request, ignored words, a seek, a failed read,
    // recalibrate and a clean retry after reset geometry
    // ------------------------------------------------------------------
    row_t dir_rows[] = '{
        '{MODE_REQ, 16'h0000, 20'h00000, 8'h00, 1, KIND_DONE, 8'h00, 20'h0},
        '{MODE_NONE, 16'hFFFF, 20'hFFFFF, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_INT, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_REQ, 16'h0000, 20'd512,   8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_REQ, 16'hFFFF, 20'hFFFFF, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_INT, 16'h0000, 20'h00000, 8'h00, 1, KIND_CMD, CMD_SENSE, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h20, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_INT, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hC0, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'hFF, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_INT, 16'h0000, 20'h00000, 8'h00, 1, KIND_CMD, CMD_SENSE, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_INT, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 0, KIND_CMD, 8'h00, 20'h0},
        '{MODE_RES, 16'h0000, 20'h00000, 8'h00, 1, KIND_DONE, 8'h00, 20'd512}
    };

    initial
    begin
        int n;
        res_word_t w;
        errors = 0; words_seen = 0; quiet_cycles = 0;
        reqs_done = 0; seek_fails = 0; retry_outs = 0;
        send_idle_pct = 36; recv_idle_pct = 59;
        // reset state of the model
        g_heads = 2'd2; g_spt = 6'd18; g_gap = 8'd27; g_drive = 2'd0; g_retry = 4'd10;
        m_phase = PH_IDLE; m_cur_trk = TRACK_UNK; m_trk = '0; m_head = '0; m_sect = '0;
        m_chunk = '0; m_left = '0; m_total = '0; m_blk = '0;
        m_retries = '0; m_res_idx = '0; m_st0 = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            n = sequence_word(dir_rows[i].mode, dir_rows[i].blk, dir_rows[i].cnt,
                              dir_rows[i].st);
            if (dir_rows[i].typed) begin
                // replace the model's word with the one read off the table
                void'(cmd_words.pop_back());
                w.kind = dir_rows[i].t_kind; w.cmd = dir_rows[i].t_cmd;
                w.dma = '0; w.done = dir_rows[i].t_done; w.last = 1'b1;
                cmd_words.push_back(w);
            end
            send_word(dir_rows[i].mode, dir_rows[i].blk, dir_rows[i].cnt, dir_rows[i].st);
        end
        controller_traffic(SEG_ITEMS / 2);
        drain();

        // single head, full track, no gap, last drive, one attempt
        load_geometry(8'd1, 8'd63, 8'd0, 8'd3, 8'd1);
        controller_traffic(SEG_ITEMS);
        drain();

        // odd head count, one sector per track: tracks wrap past 255
        send_idle_pct = 59; recv_idle_pct = 36;
        load_geometry(8'd3, 8'd1, 8'd255, 8'd2, 8'd15);
        controller_traffic(SEG_ITEMS);
        drain();

        // zero geometry counts as one; zero retry limit counts as one
        send_idle_pct = 0; recv_idle_pct = 0;
        load_geometry(8'd0, 8'd0, 8'($urandom), 8'd1, 8'd0);
        controller_traffic(SEG_ITEMS / 2);
        drain();

        load_geometry(8'd2, 8'($urandom_range(1, 63)), 8'($urandom), 8'($urandom_range(0, 3)),
                      8'($urandom_range(1, 4)));
        controller_traffic(SEG_ITEMS);
        drain();

        $display("Covered %0d result words: %0d requests finished, %0d seek failures,",
                 words_seen, reqs_done, seek_fails);
        $display("%0d retry give-ups, across five drive geometries and three stall mixes",
                 retry_outs);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
